// File: hw/rtl/i2cmra_pkg.sv
// ----------------------------------------------------------------------------
// i2cmra_pkg: shared types and codes of the I2C register access master
// Segment codes, request codes and the transaction state record.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmra_pkg;

  localparam int unsigned STEP_W  = 5;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned BIT_W   = 4;
  localparam int unsigned TICK_W  = 16;

  // transaction segments
  localparam logic [STEP_W-1:0] SEG_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] SEG_STOP_PRE = 5'd1;
  localparam logic [STEP_W-1:0] SEG_START    = 5'd2;
  localparam logic [STEP_W-1:0] SEG_TX_DEV   = 5'd3;
  localparam logic [STEP_W-1:0] SEG_TX_REG   = 5'd4;
  localparam logic [STEP_W-1:0] SEG_TX_DATA  = 5'd5;
  localparam logic [STEP_W-1:0] SEG_STOP_END = 5'd6;
  localparam logic [STEP_W-1:0] SEG_RESTART  = 5'd7;
  localparam logic [STEP_W-1:0] SEG_TX_DEVR  = 5'd8;
  localparam logic [STEP_W-1:0] SEG_RX       = 5'd9;

  // request selector
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] READ_BIT = 8'h01;

  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [PHASE_W-1:0] phase;
    logic [BIT_W-1:0]   bit_idx;
    logic [7:0]         shift_byte;
    logic [TICK_W-1:0]  tick_rem;
    logic [7:0]         saved_dev;
    logic [7:0]         saved_reg;
    logic [7:0]         saved_data;
    logic               is_read;
    logic               last_ack;
    logic [7:0]         rx_byte;
    logic               scl;
    logic               sda;
    logic               sda_drv;
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access: tick-paced I2C single register master
// Runs register write and register read transactions one pin phase at a time,
// advanced by tick beats, and returns one status beat per input beat.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in_     | input     | in_valid / in_ready  | req_type, addresses, data, sda
//  out_    | output    | out_valid/out_ready  | pins, busy, done, ack, read byte, ignored
//  cfg_    | input     | cfg_wr_en            | phase_ticks (16 bit)
//
//  The sequencer state and the result register update at the edge that
//  accepts an input beat, so a new beat can enter every cycle while results
//  drain. in_ready drops only while a result waits and out_ready is low.
//  Reset (rst_n low, synchronous) puts the bus lines high, the sequencer
//  idle and phase_ticks at 1. A stalled result holds the whole block.
//
`default_nettype none

module i2c_master_register_access
  import i2cmra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_device_addr,
  input  wire logic [7:0]  in_reg_addr,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        in_sda_in,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_scl_out,
  output logic             out_sda_out,
  output logic             out_sda_drive_enable,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic             out_ack_level,
  output logic [7:0]       out_read_data,
  output logic             out_request_ignored,

  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  // --- configuration ---
  logic [TICK_W-1:0] phase_ticks_r;
  logic [TICK_W-1:0] hold_ticks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= 16'd1;
    end else if (cfg_wr_en) begin
      phase_ticks_r <= cfg_wr_data;
    end
  end

  // a zero hold count behaves as one
  assign hold_ticks = (phase_ticks_r == '0) ? 16'd1 : phase_ticks_r;

  // --- sequencer state ---
  // idle, bus lines driven high, no acknowledge seen yet
  localparam state_t ST_RESET = '{step: SEG_IDLE, last_ack: 1'b1, scl: 1'b1,
                                  sda: 1'b1, sda_drv: 1'b1, default: '0};

  state_t st_r, st_nxt;
  state_t ph_in, ph_out;
  logic   ph_done;
  logic   is_req, busy, accept;
  logic   done_nxt, ignored_nxt;

  assign accept = in_valid && in_ready;
  assign busy   = st_r.step != SEG_IDLE;
  assign is_req = (in_req_type == REQ_WRITE) || (in_req_type == REQ_READ);

  // Load the request into the state before its first phase: same step.
  always_comb begin
    ph_in = st_r;
    if (is_req && !busy) begin
      ph_in.saved_dev  = in_device_addr;
      ph_in.saved_reg  = in_reg_addr;
      ph_in.saved_data = in_write_data;
      ph_in.is_read    = in_req_type == REQ_READ;
      ph_in.step       = (in_req_type == REQ_READ) ? SEG_START : SEG_STOP_PRE;
      ph_in.phase      = '0;
      ph_in.bit_idx    = '0;
      ph_in.shift_byte = '0;
    end
  end

  i2cmra_phase u_phase (
    .cur    (ph_in),
    .sda_in (in_sda_in),
    .nxt    (ph_out),
    .done   (ph_done)
  );

  always_comb begin
    st_nxt      = st_r;
    done_nxt    = 1'b0;
    ignored_nxt = 1'b0;
    if (is_req) begin
      if (busy) begin
        // drop the request; it does not count as a tick
        ignored_nxt = 1'b1;
      end else begin
        st_nxt          = ph_out;
        st_nxt.tick_rem = hold_ticks;
      end
    end else if (busy) begin
      if (st_r.tick_rem > 16'd1) begin
        st_nxt.tick_rem = st_r.tick_rem - 16'd1;
      end else begin
        // hold elapsed: advance one phase and rearm unless finished
        st_nxt   = ph_out;
        done_nxt = ph_done;
        if (ph_out.step != SEG_IDLE) begin
          st_nxt.tick_rem = hold_ticks;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // --- result register ---
  logic out_valid_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_scl_out          <= st_nxt.scl;
      out_sda_out          <= st_nxt.sda;
      out_sda_drive_enable <= st_nxt.sda_drv;
      out_busy_res         <= st_nxt.step != SEG_IDLE;
      out_done_res         <= done_nxt;
      out_ack_level        <= st_nxt.last_ack;
      out_read_data        <= st_nxt.rx_byte;
      out_request_ignored  <= ignored_nxt;
    end
  end

  // --- assertions ---
  a_idle_no_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.step != SEG_IDLE) == (st_r.tick_rem != '0))
    else $error("hold counter out of step with busy state");

  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_res) |-> !out_busy_res)
    else $error("done beat while still busy");

  a_ignored_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_request_ignored) |-> (out_busy_res && !out_done_res))
    else $error("dropped request without a running transaction");

  a_tx_phase : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.step == SEG_TX_DEV || st_r.step == SEG_TX_REG ||
     st_r.step == SEG_TX_DATA || st_r.step == SEG_TX_DEVR) |-> (st_r.phase != 3'd7))
    else $error("byte segment reached an unused phase");

endmodule

`default_nettype wire

// File: hw/rtl/i2cmra_phase.sv
// ----------------------------------------------------------------------------
// i2cmra_phase: one pin phase of the transaction sequencer
// Applies one pin change to the state and moves to the next segment at the
// end of a segment.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmra_phase
  import i2cmra_pkg::*;
(
  input  wire state_t cur,
  input  wire logic   sda_in,
  output state_t      nxt,
  output logic        done
);

  function automatic state_t enter_seg(input state_t s, input logic [STEP_W-1:0] seg);
    state_t r;
    r = s;
    r.step    = seg;
    r.phase   = '0;
    r.bit_idx = '0;
    case (seg)
      SEG_TX_DEV:  r.shift_byte = s.saved_dev;
      SEG_TX_REG:  r.shift_byte = s.saved_reg;
      SEG_TX_DATA: r.shift_byte = s.saved_data;
      SEG_TX_DEVR: r.shift_byte = s.saved_dev | READ_BIT;
      default:     r.shift_byte = '0;
    endcase
    if (seg == SEG_IDLE) begin
      r.tick_rem = '0;
    end
    return r;
  endfunction

  logic [STEP_W-1:0] next_seg;
  logic              fin;
  logic [BIT_W-1:0]  bit_inc;
  state_t            s;

  assign bit_inc = cur.bit_idx + 1'b1;

  always_comb begin
    case (cur.step)
      SEG_STOP_PRE: next_seg = SEG_START;
      SEG_START:    next_seg = SEG_TX_DEV;
      SEG_TX_DEV:   next_seg = SEG_TX_REG;
      SEG_TX_REG:   next_seg = cur.is_read ? SEG_RESTART : SEG_TX_DATA;
      SEG_TX_DATA:  next_seg = SEG_STOP_END;
      SEG_RESTART:  next_seg = SEG_TX_DEVR;
      SEG_TX_DEVR:  next_seg = SEG_RX;
      SEG_RX:       next_seg = SEG_STOP_END;
      default:      next_seg = SEG_IDLE;
    endcase
  end

  always_comb begin
    s   = cur;
    fin = 1'b0;
    case (cur.step)
      SEG_STOP_PRE, SEG_STOP_END: begin
        if (cur.phase == 3'd0) begin
          s.sda_drv = 1'b1; s.sda = 1'b0; s.phase = 3'd1;
        end else if (cur.phase == 3'd1) begin
          s.scl = 1'b1; s.phase = 3'd2;
        end else begin
          s.sda_drv = 1'b1; s.sda = 1'b1; fin = 1'b1;
        end
      end
      SEG_START, SEG_RESTART: begin
        if (cur.phase == 3'd0) begin
          s.sda_drv = 1'b1; s.sda = 1'b1; s.phase = 3'd1;
        end else if (cur.phase == 3'd1) begin
          s.scl = 1'b1; s.phase = 3'd2;
        end else if (cur.phase == 3'd2) begin
          s.sda_drv = 1'b1; s.sda = 1'b0; s.phase = 3'd3;
        end else begin
          s.scl = 1'b0; fin = 1'b1;
        end
      end
      SEG_TX_DEV, SEG_TX_REG, SEG_TX_DATA, SEG_TX_DEVR: begin
        case (cur.phase)
          3'd0: begin
            s.sda_drv = 1'b1;
            s.sda     = (cur.shift_byte & MSB_MASK) != 8'd0;
            s.phase   = 3'd1;
          end
          3'd1: begin
            s.scl = 1'b1; s.phase = 3'd2;
          end
          3'd2: begin
            s.scl        = 1'b0;
            s.shift_byte = {cur.shift_byte[6:0], 1'b0};
            s.bit_idx    = bit_inc;
            s.phase      = (bit_inc < 4'd8) ? 3'd0 : 3'd3;
          end
          3'd3: begin
            s.sda_drv = 1'b1; s.sda = 1'b1; s.phase = 3'd4;
          end
          3'd4: begin
            s.sda_drv = 1'b0; s.phase = 3'd5;
          end
          3'd5: begin
            s.scl = 1'b1; s.phase = 3'd6;
          end
          default: begin
            s.last_ack = sda_in;
            s.scl      = 1'b0;
            s.sda_drv  = 1'b1;
            s.sda      = 1'b0;
            fin        = 1'b1;
          end
        endcase
      end
      SEG_RX: begin
        case (cur.phase)
          3'd0: begin
            s.sda_drv = 1'b0; s.phase = 3'd1;
          end
          3'd1: begin
            s.scl = 1'b0; s.phase = 3'd2;
          end
          3'd2: begin
            s.scl = 1'b1; s.phase = 3'd3;
          end
          3'd3: begin
            s.shift_byte = {cur.shift_byte[6:0], sda_in};
            s.bit_idx    = bit_inc;
            s.phase      = (bit_inc < 4'd8) ? 3'd1 : 3'd4;
          end
          3'd4: begin
            s.scl = 1'b0; s.phase = 3'd5;
          end
          3'd5: begin
            s.sda_drv = 1'b1; s.sda = 1'b0; s.phase = 3'd6;
          end
          3'd6: begin
            s.scl = 1'b1; s.phase = 3'd7;
          end
          default: begin
            s.scl     = 1'b0;
            s.rx_byte = cur.shift_byte;
            fin       = 1'b1;
          end
        endcase
      end
      default: begin
        // unknown segment: drop back to idle
        s.step     = SEG_IDLE;
        s.tick_rem = '0;
      end
    endcase
    if (fin) begin
      nxt = enter_seg(s, next_seg);
    end else begin
      nxt = s;
    end
    done = fin && (next_seg == SEG_IDLE);
  end

endmodule

`default_nettype wire

// File: test/i2c_master_register_access_checker.sv
// ----------------------------------------------------------------------------
// i2c_bus_status_checker: status predictor and scoreboard
// Tracks the register access master one pin phase at a time, queues one
// expected status beat per accepted input beat and compares each returned
// status beat, field by field, against the oldest one in the queue.
// ----------------------------------------------------------------------------
module i2c_bus_status_checker
  import i2cmra_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_device_addr,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_write_data,
  input  logic        in_sda_in,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_scl_out,
  input  logic        out_sda_out,
  input  logic        out_sda_drive_enable,
  input  logic        out_busy_res,
  input  logic        out_done_res,
  input  logic        out_ack_level,
  input  logic [7:0]  out_read_data,
  input  logic        out_request_ignored,

  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,

  output int          fail_count,
  output int          pending,
  output logic        model_busy
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    logic       ack;
    logic [7:0] rdata;
    logic       ignored;
  } bus_status_t;

  typedef struct packed {
    logic [STEP_W-1:0]  seg;
    logic [PHASE_W-1:0] phase;
    logic [BIT_W-1:0]   nbits;
    logic [7:0]         shifter;
    logic [TICK_W-1:0]  hold_left;
    logic [7:0]         dev_byte;
    logic [7:0]         reg_byte;
    logic [7:0]         data_byte;
    logic               rd_mode;
    logic               ack_seen;
    logic [7:0]         rx_byte;
    logic               scl;
    logic               sda;
    logic               drv;
  } bus_model_t;

  bus_model_t        bus;
  logic [TICK_W-1:0] ticks_per_phase;
  logic              done_pulse;
  bus_status_t       status_due[$];
  bus_status_t       want;
  bus_status_t       got;
  bus_status_t       fresh;
  int                status_beats;

  // a zero setting still holds each phase for one tick
  function automatic logic [TICK_W-1:0] hold_len();
    return (ticks_per_phase == '0) ? TICK_W'(1) : ticks_per_phase;
  endfunction

  task automatic open_segment(input logic [STEP_W-1:0] seg);
    bus.seg   = seg;
    bus.phase = '0;
    bus.nbits = '0;
    case (seg)
      SEG_TX_DEV:  bus.shifter = bus.dev_byte;
      SEG_TX_REG:  bus.shifter = bus.reg_byte;
      SEG_TX_DATA: bus.shifter = bus.data_byte;
      SEG_TX_DEVR: bus.shifter = bus.dev_byte | READ_BIT;
      default:     bus.shifter = '0;
    endcase
    if (seg == SEG_IDLE) begin
      done_pulse    = 1'b1;
      bus.hold_left = '0;
    end
  endtask

  task automatic close_segment();
    logic [STEP_W-1:0] nxt;
    case (bus.seg)
      SEG_STOP_PRE: nxt = SEG_START;
      SEG_START:    nxt = SEG_TX_DEV;
      SEG_TX_DEV:   nxt = SEG_TX_REG;
      SEG_TX_REG:   nxt = bus.rd_mode ? SEG_RESTART : SEG_TX_DATA;
      SEG_TX_DATA:  nxt = SEG_STOP_END;
      SEG_RESTART:  nxt = SEG_TX_DEVR;
      SEG_TX_DEVR:  nxt = SEG_RX;
      SEG_RX:       nxt = SEG_STOP_END;
      default:      nxt = SEG_IDLE;
    endcase
    open_segment(nxt);
  endtask

  // one pin change of the current segment
  task automatic pin_phase(input logic sda_line);
    case (bus.seg)
      SEG_STOP_PRE, SEG_STOP_END: begin
        if (bus.phase == 3'd0) begin
          bus.drv = 1'b1; bus.sda = 1'b0; bus.phase = 3'd1;
        end else if (bus.phase == 3'd1) begin
          bus.scl = 1'b1; bus.phase = 3'd2;
        end else begin
          bus.drv = 1'b1; bus.sda = 1'b1;
          close_segment();
        end
      end
      SEG_START, SEG_RESTART: begin
        if (bus.phase == 3'd0) begin
          bus.drv = 1'b1; bus.sda = 1'b1; bus.phase = 3'd1;
        end else if (bus.phase == 3'd1) begin
          bus.scl = 1'b1; bus.phase = 3'd2;
        end else if (bus.phase == 3'd2) begin
          bus.drv = 1'b1; bus.sda = 1'b0; bus.phase = 3'd3;
        end else begin
          bus.scl = 1'b0;
          close_segment();
        end
      end
      SEG_TX_DEV, SEG_TX_REG, SEG_TX_DATA, SEG_TX_DEVR: begin
        case (bus.phase)
          3'd0: begin
            bus.drv = 1'b1; bus.sda = |(bus.shifter & MSB_MASK); bus.phase = 3'd1;
          end
          3'd1: begin
            bus.scl = 1'b1; bus.phase = 3'd2;
          end
          3'd2: begin
            bus.scl     = 1'b0;
            bus.shifter = bus.shifter << 1;
            bus.nbits   = bus.nbits + 1'b1;
            bus.phase   = (bus.nbits < 8) ? 3'd0 : 3'd3;
          end
          3'd3: begin
            bus.drv = 1'b1; bus.sda = 1'b1; bus.phase = 3'd4;
          end
          3'd4: begin
            bus.drv = 1'b0; bus.phase = 3'd5;
          end
          3'd5: begin
            bus.scl = 1'b1; bus.phase = 3'd6;
          end
          default: begin
            bus.ack_seen = sda_line;
            bus.scl      = 1'b0;
            bus.drv      = 1'b1;
            bus.sda      = 1'b0;
            close_segment();
          end
        endcase
      end
      SEG_RX: begin
        case (bus.phase)
          3'd0: begin
            bus.drv = 1'b0; bus.phase = 3'd1;
          end
          3'd1: begin
            bus.scl = 1'b0; bus.phase = 3'd2;
          end
          3'd2: begin
            bus.scl = 1'b1; bus.phase = 3'd3;
          end
          3'd3: begin
            bus.shifter = {bus.shifter[6:0], sda_line};
            bus.nbits   = bus.nbits + 1'b1;
            bus.phase   = (bus.nbits < 8) ? 3'd1 : 3'd4;
          end
          3'd4: begin
            bus.scl = 1'b0; bus.phase = 3'd5;
          end
          3'd5: begin
            bus.drv = 1'b1; bus.sda = 1'b0; bus.phase = 3'd6;
          end
          3'd6: begin
            bus.scl = 1'b1; bus.phase = 3'd7;
          end
          default: begin
            bus.scl     = 1'b0;
            bus.rx_byte = bus.shifter;
            close_segment();
          end
        endcase
      end
      default: begin
        bus.seg       = SEG_IDLE;
        bus.hold_left = '0;
      end
    endcase
  endtask

  task automatic predict_bus_status(input logic [1:0] sel, input logic [7:0] dev,
                                    input logic [7:0] regb, input logic [7:0] dat,
                                    input logic sda_line, output bus_status_t res);
    logic was_busy;
    logic dropped;
    was_busy   = (bus.seg != SEG_IDLE);
    dropped    = 1'b0;
    done_pulse = 1'b0;
    if (sel == REQ_WRITE || sel == REQ_READ) begin
      if (was_busy) begin
        dropped = 1'b1;
      end else begin
        bus.dev_byte  = dev;
        bus.reg_byte  = regb;
        bus.data_byte = dat;
        bus.rd_mode   = (sel == REQ_READ);
        open_segment(bus.rd_mode ? SEG_START : SEG_STOP_PRE);
        pin_phase(sda_line);
        bus.hold_left = hold_len();
      end
    end else if (was_busy) begin
      if (bus.hold_left > 1) begin
        bus.hold_left = bus.hold_left - 1'b1;
      end else begin
        pin_phase(sda_line);
        if (bus.seg != SEG_IDLE) bus.hold_left = hold_len();
      end
    end
    res.scl     = bus.scl;
    res.sda     = bus.sda;
    res.drv     = bus.drv;
    res.busy    = (bus.seg != SEG_IDLE);
    res.done    = done_pulse;
    res.ack     = bus.ack_seen;
    res.rdata   = bus.rx_byte;
    res.ignored = dropped;
  endtask

  task automatic note_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string fname, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v)
      note_error($sformatf("status beat %0d: %s expected %0h, got %0h",
                           status_beats, fname, want_v, got_v));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_phase = TICK_W'(1);
      bus             = '0;
      bus.ack_seen    = 1'b1;
      bus.scl         = 1'b1;
      bus.sda         = 1'b1;
      bus.drv         = 1'b1;
      status_due.delete();
    end else begin
      // retire a status beat before queueing a new one
      if (out_valid && out_ready) begin
        got = {out_scl_out, out_sda_out, out_sda_drive_enable, out_busy_res,
               out_done_res, out_ack_level, out_read_data, out_request_ignored};
        status_beats++;
        if (status_due.size() == 0) begin
          note_error($sformatf("status beat %0d arrived with nothing expected", status_beats));
        end else begin
          want = status_due.pop_front();
          check_field("scl_out", want.scl, got.scl);
          check_field("sda_out", want.sda, got.sda);
          check_field("sda_drive_enable", want.drv, got.drv);
          check_field("busy_res", want.busy, got.busy);
          check_field("done_res", want.done, got.done);
          check_field("ack_level", want.ack, got.ack);
          check_field("read_data", want.rdata, got.rdata);
          check_field("request_ignored", want.ignored, got.ignored);
        end
      end
      if (in_valid && in_ready) begin
        predict_bus_status(in_req_type, in_device_addr, in_reg_addr, in_write_data,
                           in_sda_in, fresh);
        status_due.push_back(fresh);
      end
      if (cfg_wr_en) ticks_per_phase = cfg_wr_data;
    end
    pending    <= status_due.size();
    model_busy <= (bus.seg != SEG_IDLE);
  end

endmodule

// File: test/tb_i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_register_access: testbench top of the I2C register master
// Drives tick and request beats with random gaps and output stalls, steps
// the phase hold setting through its extremes, and reports the verdict from
// the failure count of the status checker.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_access
  import i2cmra_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // selector three is not decoded as a request and behaves as a tick
  localparam logic [1:0] REQ_SPARE   = 2'd3;
  // longest stretch without any handshake before the run is declared hung
  localparam int         QUIET_LIMIT = 1000;

  typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;

  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type    = REQ_TICK;
  logic [7:0]  in_device_addr = '0;
  logic [7:0]  in_reg_addr    = '0;
  logic [7:0]  in_write_data  = '0;
  logic        in_sda_in      = 1'b1;

  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_sda_drive_enable;
  logic        out_busy_res;
  logic        out_done_res;
  logic        out_ack_level;
  logic [7:0]  out_read_data;
  logic        out_request_ignored;

  logic        cfg_wr_en      = 1'b0;
  logic [15:0] cfg_wr_data    = '0;

  int          fail_count;
  int          pending;
  logic        model_busy;

  bit          send_gaps      = 1'b0;
  bit          recv_stalls    = 1'b0;
  int          beats_sent     = 0;
  int          quiet_cycles   = 0;
  int          budget;

  // phase hold settings of the random part and the beats spent on each
  logic [15:0] tick_plan[2]   = '{16'd1, 16'd0};
  int          beat_plan[2]   = '{100, 80};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_master_register_access dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_device_addr       (in_device_addr),
    .in_reg_addr          (in_reg_addr),
    .in_write_data        (in_write_data),
    .in_sda_in            (in_sda_in),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_scl_out          (out_scl_out),
    .out_sda_out          (out_sda_out),
    .out_sda_drive_enable (out_sda_drive_enable),
    .out_busy_res         (out_busy_res),
    .out_done_res         (out_done_res),
    .out_ack_level        (out_ack_level),
    .out_read_data        (out_read_data),
    .out_request_ignored  (out_request_ignored),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  i2c_bus_status_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_device_addr       (in_device_addr),
    .in_reg_addr          (in_reg_addr),
    .in_write_data        (in_write_data),
    .in_sda_in            (in_sda_in),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_scl_out          (out_scl_out),
    .out_sda_out          (out_sda_out),
    .out_sda_drive_enable (out_sda_drive_enable),
    .out_busy_res         (out_busy_res),
    .out_done_res         (out_done_res),
    .out_ack_level        (out_ack_level),
    .out_read_data        (out_read_data),
    .out_request_ignored  (out_request_ignored),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .fail_count           (fail_count),
    .pending              (pending),
    .model_busy           (model_busy)
  );

  function automatic logic pick_sda(input sda_mode_t mode);
    case (mode)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Drive one input beat and hold it until the block takes it. A random
  // gap may come first; valid is only lowered for a gap, never between two
  // back-to-back beats.
  task automatic send_beat(input logic [1:0] sel, input logic [7:0] dev,
                           input logic [7:0] regb, input logic [7:0] dat,
                           input logic sda_line);
    if (send_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= sel;
    in_device_addr <= dev;
    in_reg_addr    <= regb;
    in_write_data  <= dat;
    in_sda_in      <= sda_line;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Advance the bus by one tick; the address fields are don't-care here, so
  // fill them with junk.
  task automatic send_tick(input logic sda_line);
    send_beat(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom), sda_line);
  endtask

  // Issue one request, then pace it with ticks until the predicted bus goes
  // idle. With noise on, scatter requests (dropped while busy) and
  // selector-three ticks among the plain ticks. The busy flag may lag one
  // beat, which at worst costs an extra idle tick or leaves a stray
  // transaction for the next settle.
  task automatic run_transaction(input logic [1:0] sel, input logic [7:0] dev,
                                 input logic [7:0] regb, input logic [7:0] dat,
                                 input sda_mode_t mode, input int noise_pct);
    int roll;
    send_beat(sel, dev, regb, dat, pick_sda(mode));
    do begin
      roll = $urandom_range(0, 99);
      if (roll < noise_pct)
        send_beat($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, 8'($urandom),
                  8'($urandom), 8'($urandom), pick_sda(mode));
      else if (roll < 2 * noise_pct)
        send_beat(REQ_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), pick_sda(mode));
      else
        send_tick(pick_sda(mode));
    end while (model_busy);
  endtask

  // Drop valid, let every status beat come back, then tick any transaction
  // still on the bus to its end and drain again.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    while (model_busy) send_tick(1'b1);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write the phase hold only with the channels and the bus both quiet.
  task automatic set_phase_ticks(input logic [15:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Receiver side: hold ready high, drop it now and then for a burst.
  initial begin
    forever begin
      if (recv_stalls && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Ticks while idle must change nothing, for selector
    // zero and selector three alike.
    send_tick(1'b0);
    send_beat(REQ_SPARE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    // write with all-ones device address and data, zero register address, every byte acknowledged
    run_transaction(REQ_WRITE, 8'hFF, 8'h00, 8'hFF, SDA_LOW, 0);
    settle();
    // read with every sampled bit high: all-ones byte, NACKed addresses
    run_transaction(REQ_READ, 8'h00, 8'hFF, 8'h00, SDA_HIGH, 0);
    settle();
    // requests and selector three arriving while the bus is busy
    run_transaction(REQ_WRITE, 8'hA5, 8'h5A, 8'h00, SDA_RANDOM, 15);
    // a zero hold setting behaves as one tick per phase
    set_phase_ticks(16'd0);
    run_transaction(REQ_READ, 8'hFE, 8'h80, 8'h01, SDA_RANDOM, 0);
    set_phase_ticks(16'd2);
    run_transaction(REQ_WRITE, 8'h01, 8'h7F, 8'h80, SDA_HIGH, 0);

    // Random part: mostly complete transactions with random content,
    // plus short bursts of fully random beats.
    foreach (tick_plan[i]) begin
      set_phase_ticks(tick_plan[i]);
      send_gaps   = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);
      budget      = beats_sent + beat_plan[i];
      while (beats_sent < budget) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 8))
            send_beat(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom));
        end else begin
          run_transaction($urandom_range(0, 1) ? REQ_WRITE : REQ_READ,
                          8'($urandom), 8'($urandom), 8'($urandom),
                          ($urandom_range(0, 5) == 0) ? SDA_LOW : SDA_RANDOM, 4);
        end
      end
    end

    // Last part, no idling on either side: the longest hold. Start a write
    // and count the hold down for a few dozen ticks, then stop with the bus
    // busy.
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    set_phase_ticks(16'hFFFF);
    send_beat(REQ_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    repeat (40) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(REQ_READ, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      else
        send_tick(1'($urandom));
    end

    // Drain: drop valid, wait for the last status beat, then a few cycles
    // more to catch anything stray.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
